/* src/dsbm_pkg.sv */
// shared types and constants for the die signature best-match core
// no dependencies; imported by the table, the scoring unit and the top level
`default_nettype none

package dsbm_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int CFG_W       = 9;
   localparam int SLOT_W      = 8;
   localparam int CODE_W      = 16;
   localparam int BYTE_W      = 8;
   localparam int PRES_W      = 6;
   localparam int LEVEL_W     = 2;
   localparam int SCORE_W     = 4;

   localparam int REQ_DATA_W  = 144;
   localparam int RSP_DATA_W  = 16;

   // presence flag positions
   localparam int PRES_SUB  = 0;
   localparam int PRES_SELF = 1;
   localparam int PRES_REV  = 2;
   localparam int PRES_CFG  = 3;
   localparam int PRES_FAB  = 4;
   localparam int PRES_FUSE = 5;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [LEVEL_W-1:0] LEVEL_BEST = 2'd3;
   localparam logic [LEVEL_W-1:0] LEVEL_HIGH = 2'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_NONE = 2'd0;

   typedef struct packed {
      logic [PRES_W-1:0] present;
      logic [CODE_W-1:0] fuse_mask;
      logic [CODE_W-1:0] cfg_mask;
      logic [CODE_W-1:0] fuse_code;
      logic [CODE_W-1:0] cfg_code;
      logic [BYTE_W-1:0] fab_code;
      logic [BYTE_W-1:0] rev_code;
      logic [CODE_W-1:0] self_code;
      logic [CODE_W-1:0] sub_code;
      logic [CODE_W-1:0] ver_code;
   } entry_type;

   typedef struct packed {
      logic [CODE_W-1:0] fuse_code;
      logic [CODE_W-1:0] cfg_code;
      logic [BYTE_W-1:0] fab_code;
      logic [BYTE_W-1:0] rev_code;
      logic [CODE_W-1:0] self_code;
      logic [CODE_W-1:0] sub_code;
      logic [CODE_W-1:0] ver_code;
   } query_type;

   typedef struct packed {
      logic               hit;
      logic [LEVEL_W-1:0] level;
   } score_type;

endpackage

`default_nettype wire

/* src/dsbm_table.sv */
// signature table: one write port, one read port with registered read data
// depends on dsbm_pkg for the entry layout and depth
`default_nettype none

module dsbm_table
   import dsbm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire entry_type         wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output entry_type              rd_data_ff
);

   entry_type mem [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* src/dsbm_score.sv */
// scoring unit shared by every entry of a scan: version hit and level 0..3
// depends on dsbm_pkg for the entry, query and score types
`default_nettype none

module dsbm_score
   import dsbm_pkg::*;
(
   input  wire entry_type entry,
   input  wire query_type query,
   output score_type      score
);

   logic [SCORE_W-1:0] weight;
   logic [SCORE_W-1:0] ok;
   logic [SCORE_W+1:0] ok3;
   logic [SCORE_W+1:0] w2;
   logic [SCORE_W+1:0] w3;

   always_comb begin
      weight = '0;
      ok     = '0;
      if (entry.present[PRES_SUB]) begin
         weight = weight + SCORE_W'(2);
         if (entry.sub_code == query.sub_code) ok = ok + SCORE_W'(2);
      end
      if (entry.present[PRES_SELF]) begin
         weight = weight + SCORE_W'(1);
         if (entry.self_code == query.self_code) ok = ok + SCORE_W'(1);
      end
      if (entry.present[PRES_REV]) begin
         weight = weight + SCORE_W'(1);
         if (entry.rev_code == query.rev_code) ok = ok + SCORE_W'(1);
      end
      if (entry.present[PRES_CFG]) begin
         weight = weight + SCORE_W'(2);
         if (((entry.cfg_code ^ query.cfg_code) & entry.cfg_mask) == '0) begin
            ok = ok + SCORE_W'(2);
         end
      end
      if (entry.present[PRES_FAB]) begin
         weight = weight + SCORE_W'(1);
         if (entry.fab_code == query.fab_code) ok = ok + SCORE_W'(1);
      end
      if (entry.present[PRES_FUSE]) begin
         weight = weight + SCORE_W'(1);
         if (((entry.fuse_code ^ query.fuse_code) & entry.fuse_mask) == '0) begin
            ok = ok + SCORE_W'(1);
         end
      end
   end

   // floor(3*ok/weight) by threshold compares; no optional field gives the top level
   always_comb begin
      ok3 = (SCORE_W+2)'(ok) * (SCORE_W+2)'(3);
      w2  = (SCORE_W+2)'(weight) * (SCORE_W+2)'(2);
      w3  = (SCORE_W+2)'(weight) * (SCORE_W+2)'(3);
      score.hit = (entry.ver_code == query.ver_code);
      if (ok3 >= w3) begin
         score.level = LEVEL_BEST;
      end else if (ok3 >= w2) begin
         score.level = LEVEL_HIGH;
      end else if (ok3 >= (SCORE_W+2)'(weight)) begin
         score.level = LEVEL_LOW;
      end else begin
         score.level = LEVEL_NONE;
      end
   end

endmodule

`default_nettype wire

/* src/die_signature_best_match_core.sv */
// die signature best-match core: table load, linear scan, best-level answer
// a write word is answered in the cycle after acceptance; a query answer appears
// once a scan of min(entries_in_use, depth) entries is done, one table entry per
// cycle through the single read port and shared scoring unit; ready is low during a scan
// synchronous active-high reset clears the entry count and the handshake state;
// table contents stay undefined until written, so no clearing pass is needed
`default_nettype none

module die_signature_best_match_core
   import dsbm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // slot, ver_code, sub_code, self_code, rev_code, fab_code, cfg_code,
   // fuse_code, cfg_mask, fuse_mask, present_bits, zero fill
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // op
   input  wire logic                  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // match_slot, match_level, zero fill
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // found
   output logic                       rsp_tuser,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CFG_W-1:0]      csr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [CFG_W-1:0]     entries_ff, entries_in;
   logic [CNT_W-1:0]     scan_len_ff, scan_len_in;
   logic [CNT_W-1:0]     scan_idx_ff, scan_idx_in;
   logic                 pend_ff, pend_in;
   logic [ADDR_W-1:0]    pend_idx_ff, pend_idx_in;
   logic                 any_ff, any_in;
   logic [LEVEL_W-1:0]   best_lvl_ff, best_lvl_in;
   logic [ADDR_W-1:0]    best_idx_ff, best_idx_in;
   query_type            query_ff, query_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [LEVEL_W-1:0]   rsp_level_ff, rsp_level_in;

   logic                 req_acc;
   logic                 rsp_free;
   logic                 rsp_load;
   logic                 wr_en;
   logic                 rd_en;
   entry_type            wr_data;
   entry_type            rd_data;
   score_type            score;
   logic [SLOT_W-1:0]    req_slot;

   // entry fields follow the slot from the lowest bit up, ver_code first
   assign req_slot = req_tdata[7:0];
   assign wr_data  = entry_type'(req_tdata[141:8]);

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && rsp_free;
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign wr_en = req_acc && (req_tuser == OP_WRITE)
                  && (32'(req_slot) < 32'(TABLE_DEPTH));
   assign rd_en = (state_ff == ST_SCAN) && (scan_idx_ff < scan_len_ff);

   dsbm_table u_table (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (ADDR_W'(req_slot)),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (scan_idx_ff[ADDR_W-1:0]),
      .rd_data_ff (rd_data)
   );

   dsbm_score u_score (
      .entry (rd_data),
      .query (query_ff),
      .score (score)
   );

   always_comb begin
      state_in     = state_ff;
      entries_in   = entries_ff;
      scan_len_in  = scan_len_ff;
      scan_idx_in  = scan_idx_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      any_in       = any_ff;
      best_lvl_in  = best_lvl_ff;
      best_idx_in  = best_idx_ff;
      query_in     = query_ff;
      rsp_load     = 1'b0;
      rsp_found_in = rsp_found_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_level_in = rsp_level_ff;

      if (csr_valid && csr_ready) begin
         entries_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_tuser == OP_QUERY) begin
                  state_in    = ST_SCAN;
                  scan_idx_in = '0;
                  any_in      = 1'b0;
                  best_lvl_in = LEVEL_NONE;
                  best_idx_in = '0;
                  query_in.ver_code  = wr_data.ver_code;
                  query_in.sub_code  = wr_data.sub_code;
                  query_in.self_code = wr_data.self_code;
                  query_in.rev_code  = wr_data.rev_code;
                  query_in.fab_code  = wr_data.fab_code;
                  query_in.cfg_code  = wr_data.cfg_code;
                  query_in.fuse_code = wr_data.fuse_code;
                  // count beyond the table depth scans the whole table
                  if (32'(entries_ff) > 32'(TABLE_DEPTH)) begin
                     scan_len_in = CNT_W'(TABLE_DEPTH);
                  end else begin
                     scan_len_in = CNT_W'(entries_ff);
                  end
               end else begin
                  rsp_load     = 1'b1;
                  rsp_found_in = 1'b0;
                  rsp_slot_in  = '0;
                  rsp_level_in = LEVEL_NONE;
               end
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               scan_idx_in = scan_idx_ff + CNT_W'(1);
               pend_in     = 1'b1;
               pend_idx_in = scan_idx_ff[ADDR_W-1:0];
            end
            // read data of the previous cycle is scored here
            if (pend_ff && score.hit) begin
               any_in = 1'b1;
               if (!any_ff || (score.level >= best_lvl_ff)) begin
                  best_lvl_in = score.level;
                  best_idx_in = pend_idx_ff;
               end
            end
            if (!rd_en && !pend_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_load     = 1'b1;
               rsp_found_in = any_ff;
               rsp_slot_in  = any_ff ? SLOT_W'(best_idx_ff) : '0;
               rsp_level_in = any_ff ? best_lvl_ff : LEVEL_NONE;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         entries_ff   <= '0;
         pend_ff      <= 1'b0;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         entries_ff   <= entries_in;
         pend_ff      <= pend_in;
         any_ff       <= any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_len_ff  <= scan_len_in;
      scan_idx_ff  <= scan_idx_in;
      pend_idx_ff  <= pend_idx_in;
      best_lvl_ff  <= best_lvl_in;
      best_idx_ff  <= best_idx_in;
      query_ff     <= query_in;
      rsp_found_ff <= rsp_found_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_level_ff <= rsp_level_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - SLOT_W - LEVEL_W){1'b0}}, rsp_level_ff, rsp_slot_ff};

`ifndef SYNTHESIS
   // a word without a version hit carries zero slot and level
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("result without hit has nonzero payload");

   // no new request is taken while a scan is under way
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == ST_IDLE)
      else $error("request ready outside idle");

   // the scan index never runs past the scan length
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> scan_idx_ff <= scan_len_ff)
      else $error("scan index beyond scan length");

   // an accepted query produces no result word in the next cycle
   a_query_no_early: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_tuser == OP_QUERY |=> !rsp_load)
      else $error("query answered before its scan");
`endif

endmodule

`default_nettype wire
